// ===== design/lcgr_pkg.sv =====
package lcgr_pkg;

   localparam int LANE_COUNT = 4;
   localparam int WORD_BITS  = 32;

   typedef logic [WORD_BITS-1:0] word_type;
   typedef logic [1:0]           lane_idx_type;

   localparam word_type LANE_MUL [LANE_COUNT] = '{
      32'd214013, 32'd17405, 32'd214013, 32'd69069
   };
   localparam word_type LANE_ADD [LANE_COUNT] = '{
      32'd2531011, 32'd10395331, 32'd13737667, 32'd1
   };

   typedef struct packed {
      logic load_seed;
      logic advance;
      logic take;
      logic step;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic lane_last;
   } ctrl_status_type;

   function automatic word_type lane_next(input word_type x, input lane_idx_type i);
      word_type prod;
      prod = x * LANE_MUL[i];
      return prod + LANE_ADD[i];
   endfunction

endpackage

// ===== design/lcgr_if.sv =====
interface lcgr_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] low;
   logic signed [31:0] high;

   modport source (output valid, output low, output high, input ready);
   modport sink   (input valid, input low, input high, output ready);
endinterface

interface lcgr_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

// ===== design/lcgr_ctrl.sv =====
module lcgr_ctrl
   import lcgr_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   input  logic            csr_write_enable,
   input  ctrl_status_type status,
   output ctrl_cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_SEED,
      S_ADV,
      S_IDLE,
      S_DIV,
      S_FIN
   } state_type;

   state_type  state_ff, state_in;
   logic [4:0] count_ff, count_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      req_ready    = 1'b0;
      if (csr_write_enable) begin
         state_in = S_SEED;
      end else begin
         unique case (state_ff)
            S_SEED: begin
               cmd.load_seed = 1'b1;
               state_in      = S_ADV;
            end
            S_ADV: begin
               cmd.advance = 1'b1;
               state_in    = S_IDLE;
            end
            S_IDLE: begin
               req_ready = 1'b1;
               if (req_valid) begin
                  cmd.take    = 1'b1;
                  cmd.advance = status.lane_last;
                  count_in    = '0;
                  state_in    = S_DIV;
               end
            end
            S_DIV: begin
               cmd.step = 1'b1;
               count_in = count_ff + 5'd1;
               if (count_ff == 5'd31) begin
                  state_in = S_FIN;
               end
            end
            S_FIN: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  cmd.finish   = 1'b1;
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end
            end
            default: state_in = S_SEED;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SEED;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== design/lcgr_datapath.sv =====
module lcgr_datapath
   import lcgr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  ctrl_cmd_type       cmd,
   output ctrl_status_type    status,
   input  logic               csr_write_enable,
   input  logic [31:0]        csr_write_data,
   input  logic signed [31:0] req_low,
   input  logic signed [31:0] req_high,
   output logic signed [31:0] rsp_value
);

   word_type     seed_ff;
   word_type     lane_ff [LANE_COUNT];
   lane_idx_type idx_ff;
   word_type     low_ff;
   word_type     span_ff;
   word_type     word_ff;
   word_type     rem_ff;
   word_type     value_ff;

   logic [WORD_BITS:0] shifted;
   logic [WORD_BITS:0] diff;
   word_type           rem_in;

   // one restoring division step per cycle
   always_comb begin
      shifted = {rem_ff, word_ff[WORD_BITS-1]};
      diff    = shifted - {1'b0, span_ff};
      if (shifted >= {1'b0, span_ff}) begin
         rem_in = diff[WORD_BITS-1:0];
      end else begin
         rem_in = shifted[WORD_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= '0;
         idx_ff  <= '0;
      end else begin
         if (csr_write_enable) begin
            seed_ff <= csr_write_data;
         end
         if (cmd.load_seed) begin
            idx_ff <= '0;
         end else if (cmd.take) begin
            idx_ff <= idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_seed) begin
         lane_ff[0] <= seed_ff + 32'd1;
         lane_ff[1] <= seed_ff;
         lane_ff[2] <= seed_ff + 32'd1;
         lane_ff[3] <= seed_ff;
      end else if (cmd.advance) begin
         for (int i = 0; i < LANE_COUNT; i++) begin
            lane_ff[i] <= lane_next(lane_ff[i], lane_idx_type'(i));
         end
      end
      if (cmd.take) begin
         low_ff  <= word_type'(req_low);
         span_ff <= word_type'(req_high) + 32'd1 - word_type'(req_low);
         word_ff <= lane_ff[idx_ff];
         rem_ff  <= '0;
      end else if (cmd.step) begin
         word_ff <= {word_ff[WORD_BITS-2:0], 1'b0};
         rem_ff  <= rem_in;
      end
      if (cmd.finish) begin
         value_ff <= low_ff + rem_ff;
      end
   end

   assign status.lane_last = (idx_ff == 2'd3);
   assign rsp_value        = signed'(value_ff);

endmodule

// ===== design/four_lane_lcg_ranged_random_core.sv =====
// channel  | direction | payload             | handshake
// req_chan | in        | low, high (s32)     | valid/ready
// rsp_chan | out       | value (s32)         | valid/ready
// csr      | in        | seed (u32)          | write_enable
//
// A request is accepted, then runs 32 steps of the radix-2 remainder
// unit, then the result register is written. One request at a time.
// After reset or a seed write the lanes load in S_SEED, then advance in S_ADV.
// The result register holds while rsp is stalled; a new request's result waits.
module four_lane_lcg_ranged_random_core
   import lcgr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   lcgr_req_if.sink    req_chan,
   lcgr_rsp_if.source  rsp_chan,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data
);

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   lcgr_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_chan.valid),
      .req_ready        (req_chan.ready),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .csr_write_enable (csr_write_enable),
      .status           (status),
      .cmd              (cmd)
   );

   lcgr_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_low          (req_chan.low),
      .req_high         (req_chan.high),
      .rsp_value        (rsp_chan.value)
   );

endmodule

// ===== sim/testbench.sv =====
module testbench;
   import lcgr_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      word_type lo;
      word_type hi;
   } range_type;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [31:0] csr_write_data;

   lcgr_req_if req_bus ();
   lcgr_rsp_if rsp_bus ();

   four_lane_lcg_ranged_random_core DUT (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_bus),
      .rsp_chan         (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   range_type  pending_ranges[$];
   word_type   predicted_values[$];
   range_type  next_range;
   word_type   lane_state [LANE_COUNT];
   logic [2:0] lane_cursor;
   word_type   want_value;
   bit         req_accepted = 1'b0;
   bit         steady_flow  = 1'b0;
   int         req_gap      = 0;
   int         rsp_stall    = 0;
   int         error_count  = 0;
   int         mismatch_count = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("simulation failed");
      $finish;
   end

   // generator model
   function automatic void advance_lanes();
      for (int i = 0; i < LANE_COUNT; i++) begin
         lane_state[i] = lane_state[i] * LANE_MUL[i] + LANE_ADD[i];
      end
   endfunction

   function automatic void load_lanes(input word_type s);
      lane_state[0] = s + 32'd1;
      lane_state[1] = s;
      lane_state[2] = s + 32'd1;
      lane_state[3] = s;
      advance_lanes();
      lane_cursor = 3'd0;
   endfunction

   function automatic word_type draw_ranged(input word_type lo, input word_type hi);
      word_type span;
      word_type word;
      if (lane_cursor >= LANE_COUNT) begin
         advance_lanes();
         lane_cursor = 3'd0;
      end
      word = lane_state[lane_cursor[1:0]];
      lane_cursor = lane_cursor + 3'd1;
      span = hi + 32'd1 - lo;
      if (span == 32'd0)
         return lo + word;
      return lo + word % span;
   endfunction

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (req_accepted || !req_bus.valid) begin
         if (req_accepted && !steady_flow && $urandom_range(0, 3) == 0)
            req_gap = $urandom_range(1, 19);
         req_accepted = 1'b0;
         if (req_gap != 0 || pending_ranges.size() == 0) begin
            if (req_gap != 0)
               req_gap--;
            req_bus.valid <= 1'b0;
         end else begin
            next_range = pending_ranges.pop_front();
            req_bus.low   <= next_range.lo;
            req_bus.high  <= next_range.hi;
            req_bus.valid <= 1'b1;
         end
      end
   end

   // response backpressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_stall == 0 && !steady_flow && $urandom_range(0, 15) == 0)
            rsp_stall = $urandom_range(1, 19);
         if (rsp_stall != 0) begin
            rsp_stall--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            predicted_values.push_back(draw_ranged(req_bus.low, req_bus.high));
            req_accepted = 1'b1;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (predicted_values.size() == 0) begin
               error_count++;
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected response: value %h", rsp_bus.value);
            end else begin
               want_value = predicted_values.pop_front();
               if (rsp_bus.value !== want_value) begin
                  error_count++;
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("value mismatch: expected %h actual %h",
                              want_value, rsp_bus.value);
               end
            end
         end
      end
   end

   task automatic queue_range(input word_type lo, input word_type hi);
      pending_ranges.push_back('{lo: lo, hi: hi});
   endtask

   task automatic wait_idle();
      while (pending_ranges.size() != 0 || req_bus.valid || predicted_values.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_seed(input word_type s);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= s;
      load_lanes(s);
      @(negedge clock);
      csr_write_enable <= 1'b0;
      csr_write_data   <= $urandom;
   endtask

   task automatic queue_random(input int count);
      word_type corner_words [6];
      word_type lo;
      word_type hi;
      corner_words = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF,
                       32'h0000_0001, 32'h8000_0001};
      for (int n = 0; n < count; n++) begin
         lo = $urandom;
         case ($urandom_range(0, 9))
            0, 1, 2: hi = lo + $urandom_range(0, 1000);
            3, 4:    hi = $urandom;
            5:       hi = lo - 32'd1;
            6: begin
               lo = 32'd0;
               hi = $urandom_range(0, 1) ? 32'($urandom_range(0, 23)) : {1'b0, 31'($urandom)};
            end
            7: begin
               hi = $urandom;
               lo = hi + $urandom_range(1, 1 << 20);
            end
            8: begin
               lo = corner_words[$urandom_range(0, 5)];
               hi = corner_words[$urandom_range(0, 5)];
            end
            default: hi = lo + $urandom;
         endcase
         queue_range(lo, hi);
      end
   endtask

   initial begin
      word_type seed_plan [6];
      seed_plan = '{32'hFFFF_FFFF, 32'h0, $urandom, 32'h8000_0000, $urandom, 32'h7FFF_FFFF};

      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data   = 32'h0;
      req_bus.valid    = 1'b0;
      req_bus.low      = 32'sh0;
      req_bus.high     = 32'sh0;
      rsp_bus.ready    = 1'b0;
      load_lanes(32'h0);
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed ranges on the reset seed
      queue_range(32'h0000_0000, 32'h0000_0000);
      queue_range(32'h8000_0000, 32'h7FFF_FFFF);
      queue_range(32'h0000_0000, 32'hFFFF_FFFF);
      queue_range(32'h0000_0001, 32'h0000_0000);
      queue_range(32'h8000_0000, 32'h8000_0000);
      queue_range(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      queue_range(32'h7FFF_FFFF, 32'h8000_0000);
      queue_range(32'h0000_0005, 32'h0000_0003);
      queue_range(32'h0000_0000, 32'd23);
      queue_range(32'h0000_0000, 32'hFFFF_FFFE);
      queue_range(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_range(32'd10, 32'd20);
      queue_range(-32'sd100, 32'sd100);
      queue_range(32'h0000_0000, 32'h7FFF_FFFF);
      queue_range(32'h8000_0000, 32'hFFFF_FFFF);
      queue_range(32'h0000_0000, 32'h0000_0001);
      queue_range(32'h0000_0000, 32'h0000_0002);
      queue_range(32'hFFFF_FFFF, 32'h0000_0000);
      queue_range(32'h5555_5555, 32'hAAAA_AAAA);
      queue_random(130);
      wait_idle();

      foreach (seed_plan[p]) begin
         write_seed(seed_plan[p]);
         if (p == 5)
            steady_flow = 1'b1;
         queue_random(135);
         wait_idle();
      end

      repeat (40) @(negedge clock);
      if (predicted_values.size() != 0)
         error_count++;
      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// ===== sim.f =====
design/lcgr_pkg.sv
design/lcgr_if.sv
design/lcgr_ctrl.sv
design/lcgr_datapath.sv
design/four_lane_lcg_ranged_random_core.sv
sim/testbench.sv
